// ===== src/g23_pkg.sv =====
package g23_pkg;

    localparam int WordBits  = 23;
    localparam int SynBits   = 11;
    localparam int PolyBits  = 12;
    localparam int CountBits = 4;
    localparam int StepBits  = 5;

    localparam logic [PolyBits-1:0]  Poly       = 12'hAE3;
    localparam logic [CountBits-1:0] LimitPlain = 4'd3;
    localparam logic [CountBits-1:0] LimitTrial = 4'd2;
    localparam logic [StepBits-1:0]  LastRot    = 5'd22;
    localparam logic [StepBits-1:0]  LastPass   = 5'd23;

    typedef logic [WordBits-1:0]  word_t;
    typedef logic [SynBits-1:0]   syn_t;
    typedef logic [CountBits-1:0] count_t;
    typedef logic [StepBits-1:0]  step_t;
    typedef syn_t                 syn_col_arr_t [WordBits];
    typedef logic [2:0]           nib_weight_arr_t [16];

    // Result of the shared syndrome unit
    typedef struct packed {
        syn_t   syndrome;
        count_t weight;
    } syn_res_t;

    localparam nib_weight_arr_t NibbleWeight = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
        3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
    };

    // Syndrome of each single-bit word: the columns of the check matrix
    function automatic syn_col_arr_t build_syn_cols();
        syn_col_arr_t cols;
        word_t        w;
        for (int i = 0; i < WordBits; i++) begin
            w = word_t'(1) << i;
            for (int k = 0; k < PolyBits; k++) begin
                if (w[0]) begin
                    w = w ^ word_t'(Poly);
                end
                w = w >> 1;
            end
            cols[i] = w[SynBits-1:0];
        end
        return cols;
    endfunction

    localparam syn_col_arr_t SynCols = build_syn_cols();

    // Rotate a word right by n places, n below the word width
    function automatic word_t rot_right(word_t w, step_t n);
        logic [2*WordBits-1:0] dbl;
        dbl = {w, w} >> n;
        return dbl[WordBits-1:0];
    endfunction

    function automatic word_t rot_left1(word_t w);
        return {w[WordBits-2:0], w[WordBits-1]};
    endfunction

endpackage

// ===== src/g23_in_if.sv =====
interface g23_in_if;
    logic           valid;
    logic           ready;
    g23_pkg::word_t received_word;

    modport source (output valid, output received_word, input ready);
    modport sink   (input valid, input received_word, output ready);
endinterface

// ===== src/g23_out_if.sv =====
interface g23_out_if;
    logic            valid;
    logic            ready;
    g23_pkg::word_t  corrected_word;
    g23_pkg::count_t error_count;
    logic            not_found;

    modport source (output valid, output corrected_word, output error_count,
                    output not_found, input ready);
    modport sink   (input valid, input corrected_word, input error_count,
                    input not_found, output ready);
endinterface

// ===== src/g23_syn_unit.sv =====
module g23_syn_unit (
    input  g23_pkg::word_t    word,
    output g23_pkg::syn_res_t res
);

    g23_pkg::syn_t syndrome;
    logic [3:0]    nib0;
    logic [3:0]    nib1;
    logic [3:0]    nib2;

    // XOR the check-matrix columns of all set bits
    always_comb
    begin
        syndrome = '0;
        for (int i = 0; i < g23_pkg::WordBits; i++) begin
            if (word[i]) begin
                syndrome = syndrome ^ g23_pkg::SynCols[i];
            end
        end
    end

    // Count syndrome bits nibble by nibble
    assign nib0 = syndrome[3:0];
    assign nib1 = syndrome[7:4];
    assign nib2 = {1'b0, syndrome[10:8]};

    assign res.syndrome = syndrome;
    assign res.weight   = g23_pkg::count_t'(g23_pkg::NibbleWeight[nib0])
                        + g23_pkg::count_t'(g23_pkg::NibbleWeight[nib1])
                        + g23_pkg::count_t'(g23_pkg::NibbleWeight[nib2]);

endmodule

// ===== src/golay_23_12_decoder.sv =====
// Golay [23,12] decoder by syndrome search. One syndrome-and-weight unit is
// evaluated once per clock on the current trial word. It runs first on the
// plain word over its 23 rotations (weight threshold 3), then on each
// single-bit flip of bits 0 to 22 over 23 rotations (threshold 2). The search
// stops at the first hit, or after the last trial when no trial matches. The
// result register loads when the search finishes and the output slot is free.
// The input is ready again in the cycle after the result loads. One codeword
// is decoded at a time: the input is ready only while the search sequencer
// is idle. A finished result waits in the output register; the next search
// may run meanwhile and holds its result until that slot frees.
module golay_23_12_decoder (
    input logic         clk,
    input logic         rst_n,
    g23_in_if.sink      codeword,
    g23_out_if.source   result
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t            state_reg;
    g23_pkg::word_t    orig_reg;
    g23_pkg::word_t    cw_reg;
    g23_pkg::step_t    pass_reg;
    g23_pkg::step_t    rot_reg;
    g23_pkg::count_t   count_reg;
    logic              out_valid_reg;
    g23_pkg::word_t    out_word_reg;
    g23_pkg::count_t   out_count_reg;
    logic              out_nf_reg;

    g23_pkg::syn_res_t syn;
    g23_pkg::count_t   limit;
    logic              hit_zero;
    logic              hit;
    logic              last_trial;
    logic              finish;
    logic              slot_free;
    logic              load_res;
    g23_pkg::word_t    fix_word;
    g23_pkg::word_t    flip_word;
    g23_pkg::word_t    res_word;
    g23_pkg::count_t   res_count;

    g23_syn_unit u_syn (
        .word (cw_reg),
        .res  (syn)
    );

    // Judge the current trial word
    assign limit      = (pass_reg == '0) ? g23_pkg::LimitPlain : g23_pkg::LimitTrial;
    assign hit_zero   = (rot_reg == '0) && (syn.syndrome == '0);
    assign hit        = (syn.weight <= limit);
    assign last_trial = (rot_reg == g23_pkg::LastRot) && (pass_reg == g23_pkg::LastPass);
    assign finish     = hit_zero || hit || last_trial;
    assign slot_free  = !out_valid_reg || result.ready;
    assign load_res   = (state_reg == S_RUN) && finish && slot_free;

    // Candidate words for a hit and for the next trial pass
    assign fix_word  = g23_pkg::rot_right(cw_reg ^ {syn.syndrome, 12'b0}, rot_reg);
    assign flip_word = orig_reg ^ (g23_pkg::word_t'(1) << pass_reg);

    // Pick the result fields
    always_comb
    begin
        if (hit_zero)
        begin
            res_word  = cw_reg;
            res_count = count_reg;
        end
        else if (hit)
        begin
            res_word  = fix_word;
            res_count = (pass_reg != '0) ? syn.weight + 4'd1 : syn.weight;
        end
        else
        begin
            res_word  = orig_reg;
            res_count = syn.weight;
        end
    end

    assign codeword.ready        = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.corrected_word = out_word_reg;
    assign result.error_count    = out_count_reg;
    assign result.not_found      = out_nf_reg;

    // Sequence the search and hold the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            orig_reg      <= '0;
            cw_reg        <= '0;
            pass_reg      <= '0;
            rot_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            out_count_reg <= '0;
            out_nf_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready && !load_res)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (codeword.valid)
                    begin
                        orig_reg  <= codeword.received_word;
                        cw_reg    <= codeword.received_word;
                        pass_reg  <= '0;
                        rot_reg   <= '0;
                        count_reg <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (finish)
                    begin
                        if (slot_free)
                        begin
                            out_valid_reg <= 1'b1;
                            out_word_reg  <= res_word;
                            out_count_reg <= res_count;
                            out_nf_reg    <= !(hit_zero || hit);
                            state_reg     <= S_IDLE;
                        end
                    end
                    else
                    begin
                        count_reg <= syn.weight;
                        if (rot_reg == g23_pkg::LastRot)
                        begin
                            pass_reg <= pass_reg + 5'd1;
                            rot_reg  <= '0;
                            cw_reg   <= flip_word;
                        end
                        else
                        begin
                            rot_reg <= rot_reg + 5'd1;
                            cw_reg  <= g23_pkg::rot_left1(cw_reg);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/g23_checker.sv =====
module g23_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input g23_pkg::word_t  corrected_word,
    input g23_pkg::count_t error_count,
    input logic            not_found
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(corrected_word)
            && $stable(error_count) && $stable(not_found))
        else $error("stalled result changed");

    // Drop ready for the search after an input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready during search");

    // Raise no new result straight after an input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result without search cycle");

    // A failed search ends on a syndrome heavier than the trial threshold
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_found |-> error_count >= 4'd3)
        else $error("not-found result with light syndrome");

endmodule

bind golay_23_12_decoder g23_checker u_g23_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (codeword.valid),
    .in_ready       (codeword.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .corrected_word (result.corrected_word),
    .error_count    (result.error_count),
    .not_found      (result.not_found)
);
